// ===== design/icm_pkg.sv =====
// Package for the triplet label update block.
// Holds mode codes, register indexes and fixed field widths; no dependencies.
package icm_pkg;
  localparam logic [2:0] MODE_LOAD_SCORE = 3'd0;
  localparam logic [2:0] MODE_LOAD_DATA  = 3'd1;
  localparam logic [2:0] MODE_SET_LABEL  = 3'd2;
  localparam logic [2:0] MODE_UPDATE     = 3'd3;
  localparam logic [2:0] MODE_READ       = 3'd4;

  localparam logic [2:0] REG_SITES = 3'd0;
  localparam logic [2:0] REG_LABELS = 3'd1;
  localparam logic [2:0] REG_SETS = 3'd2;
  localparam logic [2:0] REG_ALPHA = 3'd3;
  localparam logic [2:0] REG_SCALE = 3'd4;
  localparam logic [2:0] REG_USE_DC = 3'd5;

  localparam int LABEL_W = 3;
  localparam int SCORE_W = 16;
  localparam int ENERGY_W = 40;
  localparam logic [15:0] ZERO_PROB = 16'hFFFF;
endpackage

// ===== design/icm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module icm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== design/icm_triplet_label_update_top.sv =====
// Top level of the triplet label update block: config registers, sequencer, three RAMs.
// Depends on icm_pkg and icm_ram.
//
// Loads, set-label and ignored items finish without raising busy; a label read holds busy
// until its result. An update scans, per candidate label, the data cost (if enabled), then
// every site j other than the updated one (reading its label), then every site k other
// than j and the updated one (reading its label), reading the triplet's scores over each set,
// scaling the best sum and accumulating it; the lowest-total label is written back at the end.
// After reset the label RAM is cleared to zero while busy is high.
// done marks each result for one cycle; the receiver cannot stall.
module icm_triplet_label_update_top
  import icm_pkg::*;
#(
  parameter int MAX_SITES = 32,
  parameter int MAX_LABELS = 8,
  parameter int MAX_SETS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [1:0]  set_index,
  input  logic [4:0]  site,
  input  logic [2:0]  label,
  input  logic [15:0] value,
  output logic        done,
  output logic        result_kind,
  output logic [4:0]  out_site,
  output logic [2:0]  out_label,
  output logic [39:0] energy_times_six
);
  localparam int NS_DEPTH = MAX_SETS * MAX_LABELS * MAX_SITES;
  localparam int DC_DEPTH = MAX_LABELS * MAX_SITES;
  localparam int NAW = NS_DEPTH > 1 ? $clog2(NS_DEPTH) : 1;
  localparam int DAW = DC_DEPTH > 1 ? $clog2(DC_DEPTH) : 1;
  localparam int SAW = MAX_SITES > 1 ? $clog2(MAX_SITES) : 1;
  localparam int SCW = $clog2(MAX_SITES + 1);
  localparam int LCW = $clog2(MAX_LABELS + 1);
  localparam int TCW = $clog2(MAX_SETS + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_DC   = 4'd2;
  localparam logic [3:0] S_DCW  = 4'd3;
  localparam logic [3:0] S_LJ   = 4'd4;
  localparam logic [3:0] S_LJW  = 4'd5;
  localparam logic [3:0] S_LK   = 4'd6;
  localparam logic [3:0] S_LKW  = 4'd7;
  localparam logic [3:0] S_RA   = 4'd8;
  localparam logic [3:0] S_RB   = 4'd9;
  localparam logic [3:0] S_RC   = 4'd10;
  localparam logic [3:0] S_RD   = 4'd11;
  localparam logic [3:0] S_MUL  = 4'd12;
  localparam logic [3:0] S_ACC  = 4'd13;
  localparam logic [3:0] S_CMP  = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  logic [5:0]  active_sites;
  logic [3:0]  active_labels;
  logic [2:0]  active_sets;
  logic [15:0] alpha;
  logic [15:0] alpha_scale;
  logic        use_data_cost;

  logic [3:0]  st;
  logic        rd_pend;
  logic [4:0]  cur_site;
  logic [SCW-1:0] clr;
  logic [LCW-1:0] f;
  logic [SCW-1:0] j;
  logic [SCW-1:0] k;
  logic [TCW-1:0] t;
  logic [2:0]  lj;
  logic [2:0]  lk;
  logic [15:0] sa;
  logic [15:0] sb;
  logic [17:0] best_sum;
  logic        any;
  logic [33:0] prod;
  logic [39:0] total;
  logic [39:0] best_total;
  logic [LCW-1:0] best_lab;

  logic [SCW-1:0] ns;
  logic [LCW-1:0] nl;
  logic [TCW-1:0] nt;
  logic [17:0] sum3;
  logic [17:0] cost;

  logic           cfg_we;
  logic           acc;
  logic           ns_we;
  logic [NAW-1:0] ns_waddr;
  logic [NAW-1:0] ns_raddr;
  logic [15:0]    ns_rdata;
  logic           dc_we;
  logic [DAW-1:0] dc_waddr;
  logic [DAW-1:0] dc_raddr;
  logic [15:0]    dc_rdata;
  logic           lb_we;
  logic [SAW-1:0] lb_waddr;
  logic [2:0]     lb_wdata;
  logic [SAW-1:0] lb_raddr;
  logic [2:0]     lb_rdata;

  function automatic logic [NAW-1:0] score_addr(int unsigned s, int unsigned l,
                                                int unsigned x);
    score_addr = NAW'((s * MAX_LABELS + l) * MAX_SITES + x);
  endfunction

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign busy = (st != S_IDLE) || rd_pend;
  assign acc = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sites <= 6'd32;
      active_labels <= 4'd8;
      active_sets <= 3'd4;
      alpha <= 16'd256;
      alpha_scale <= 16'd1;
      use_data_cost <= 1'b0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        REG_SITES: active_sites <= pwdata[5:0];
        REG_LABELS: active_labels <= pwdata[3:0];
        REG_SETS: active_sets <= pwdata[2:0];
        REG_ALPHA: alpha <= pwdata[15:0];
        REG_SCALE: alpha_scale <= pwdata[15:0];
        REG_USE_DC: use_data_cost <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_SITES: prdata = {26'd0, active_sites};
      REG_LABELS: prdata = {28'd0, active_labels};
      REG_SETS: prdata = {29'd0, active_sets};
      REG_ALPHA: prdata = {16'd0, alpha};
      REG_SCALE: prdata = {16'd0, alpha_scale};
      REG_USE_DC: prdata = {31'd0, use_data_cost};
      default: prdata = 32'd0;
    endcase
  end

  always_comb begin
    ns = (int'(active_sites) > MAX_SITES) ? SCW'(MAX_SITES) : SCW'(active_sites);
    if (active_labels == 4'd0) begin
      nl = LCW'(1);
    end else if (int'(active_labels) > MAX_LABELS) begin
      nl = LCW'(MAX_LABELS);
    end else begin
      nl = LCW'(active_labels);
    end
    nt = (int'(active_sets) > MAX_SETS) ? TCW'(MAX_SETS) : TCW'(active_sets);
    sum3 = 18'(sa) + 18'(sb) + 18'(ns_rdata);
    cost = any ? prod[33:16] : 18'(alpha);
  end

  always_comb begin
    ns_we = acc && mode == MODE_LOAD_SCORE && int'(set_index) < MAX_SETS &&
            int'(label) < MAX_LABELS && int'(site) < MAX_SITES;
    ns_waddr = score_addr(set_index, label, site);
    dc_we = acc && mode == MODE_LOAD_DATA && int'(label) < MAX_LABELS &&
            int'(site) < MAX_SITES;
    dc_waddr = DAW'(int'(label) * MAX_SITES + int'(site));
    dc_raddr = DAW'(int'(f) * MAX_SITES + int'(cur_site));
    case (st)
      S_RB: ns_raddr = score_addr(t, lj, j);
      S_RC: ns_raddr = score_addr(t, lk, k);
      default: ns_raddr = score_addr(t, f, cur_site);
    endcase
    case (st)
      S_LJ: lb_raddr = SAW'(j);
      S_LK: lb_raddr = SAW'(k);
      default: lb_raddr = SAW'(site);
    endcase
    lb_we = 1'b0;
    lb_waddr = SAW'(site);
    lb_wdata = label;
    if (st == S_CLR) begin
      lb_we = 1'b1;
      lb_waddr = SAW'(clr);
      lb_wdata = 3'd0;
    end else if (st == S_FIN) begin
      lb_we = 1'b1;
      lb_waddr = SAW'(cur_site);
      lb_wdata = 3'(best_lab);
    end else if (acc && mode == MODE_SET_LABEL && int'(label) < MAX_LABELS &&
                 int'(site) < MAX_SITES) begin
      lb_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_CLR;
      clr <= '0;
      done <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      done <= 1'b0;
      rd_pend <= 1'b0;
      case (st)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (int'(clr) == MAX_SITES - 1) begin
            st <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (rd_pend) begin
            done <= 1'b1;
            result_kind <= 1'b1;
            out_site <= cur_site;
            out_label <= lb_rdata;
            energy_times_six <= '0;
          end else if (acc && int'(site) < MAX_SITES) begin
            cur_site <= site;
            if (mode == MODE_UPDATE) begin
              f <= '0;
              st <= S_DC;
            end else if (mode == MODE_READ) begin
              rd_pend <= 1'b1;
            end
          end
        end
        S_DC: st <= S_DCW;
        S_DCW: begin
          total <= use_data_cost ? 40'(ns) * 40'd6 * 40'(dc_rdata) : '0;
          j <= '0;
          st <= S_LJ;
        end
        S_LJ: begin
          if (j >= ns) begin
            st <= S_CMP;
          end else if (int'(j) == int'(cur_site)) begin
            j <= j + 1'b1;
          end else begin
            st <= S_LJW;
          end
        end
        S_LJW: begin
          lj <= lb_rdata;
          k <= '0;
          st <= S_LK;
        end
        S_LK: begin
          if (k >= ns) begin
            j <= j + 1'b1;
            st <= S_LJ;
          end else if (int'(k) == int'(cur_site) || k == j) begin
            k <= k + 1'b1;
          end else begin
            st <= S_LKW;
          end
        end
        S_LKW: begin
          lk <= lb_rdata;
          t <= '0;
          any <= 1'b0;
          st <= (nt == '0) ? S_MUL : S_RA;
        end
        S_RA: st <= S_RB;
        S_RB: begin
          sa <= ns_rdata;
          st <= S_RC;
        end
        S_RC: begin
          sb <= ns_rdata;
          st <= S_RD;
        end
        S_RD: begin
          if (sa != ZERO_PROB && sb != ZERO_PROB && ns_rdata != ZERO_PROB &&
              (!any || sum3 < best_sum)) begin
            best_sum <= sum3;
            any <= 1'b1;
          end
          t <= t + 1'b1;
          st <= (TCW'(t + 1'b1) < nt) ? S_RA : S_MUL;
        end
        S_MUL: begin
          prod <= 34'(alpha_scale) * 34'(best_sum);
          st <= S_ACC;
        end
        S_ACC: begin
          total <= total + 40'(cost) * 40'd3;
          k <= k + 1'b1;
          st <= S_LK;
        end
        S_CMP: begin
          if (f == '0 || total < best_total) begin
            best_total <= total;
            best_lab <= f;
          end
          f <= f + 1'b1;
          st <= (LCW'(f + 1'b1) < nl) ? S_DC : S_FIN;
        end
        S_FIN: begin
          done <= 1'b1;
          result_kind <= 1'b0;
          out_site <= cur_site;
          out_label <= 3'(best_lab);
          energy_times_six <= best_total;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  icm_ram #(.WIDTH(SCORE_W), .DEPTH(NS_DEPTH)) u_neglog (
    .clk(clk), .we(ns_we), .waddr(ns_waddr), .wdata(value),
    .raddr(ns_raddr), .rdata(ns_rdata)
  );

  icm_ram #(.WIDTH(SCORE_W), .DEPTH(DC_DEPTH)) u_data_cost (
    .clk(clk), .we(dc_we), .waddr(dc_waddr), .wdata(value),
    .raddr(dc_raddr), .rdata(dc_rdata)
  );

  icm_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_SITES)) u_label (
    .clk(clk), .we(lb_we), .waddr(lb_waddr), .wdata(lb_wdata),
    .raddr(lb_raddr), .rdata(lb_rdata)
  );
endmodule

// ===== design/icm_checker.sv =====
// Port-level checks for the triplet label update block, bound to its top level.
// Depends on icm_pkg.
module icm_checker
  import icm_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [2:0]  mode,
  input logic        done,
  input logic        result_kind,
  input logic [39:0] energy_times_six
);
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result while busy");

  a_read_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == MODE_READ) |=> busy ##1 (done && result_kind))
    else $error("read result missing");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (mode == MODE_LOAD_SCORE || mode == MODE_LOAD_DATA ||
                        mode == MODE_SET_LABEL)) |=> (!busy && !done))
    else $error("load stalled or produced a result");

  a_read_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result_kind) |-> energy_times_six == 40'd0)
    else $error("read with energy");
endmodule

bind icm_triplet_label_update_top icm_checker u_icm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode), .done(done),
  .result_kind(result_kind), .energy_times_six(energy_times_six)
);

// ===== verif/tb.sv =====
// Testbench for icm_triplet_label_update_top: directed and random items, APB setup,
// self-checking through a scoreboard class with its own label-update predictor.
// Depends on icm_pkg and the block's RTL only.
module tb;
  import icm_pkg::*;

  typedef struct {
    logic        kind;
    logic [4:0]  st;
    logic [2:0]  lab;
    logic [39:0] energy;
  } icm_result_t;

  class label_sb;
    logic [2:0]  labels [32];
    logic [15:0] scores [1024];
    logic [15:0] dcost  [256];
    logic [5:0]  n_sites;
    logic [3:0]  n_labels;
    logic [2:0]  n_sets;
    logic [15:0] alpha;
    logic [15:0] scale;
    logic        use_dc;
    icm_result_t pending[$];
    int          errors;

    function void reset_state();
      foreach (labels[i]) labels[i] = '0;
      foreach (scores[i]) scores[i] = '0;
      foreach (dcost[i]) dcost[i] = '0;
      n_sites = 32; n_labels = 8; n_sets = 4;
      alpha = 256; scale = 1; use_dc = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_SITES:  n_sites = v[5:0];
        REG_LABELS: n_labels = v[3:0];
        REG_SETS:   n_sets = v[2:0];
        REG_ALPHA:  alpha = v[15:0];
        REG_SCALE:  scale = v[15:0];
        REG_USE_DC: use_dc = v[0];
        default: ;
      endcase
    endfunction

    function void add_wanted(icm_result_t r);
      pending.insert(pending.size(), r);
    endfunction

    function longint triplet(int s0, int l0, int s1, int l1, int s2, int l2, int nt);
      bit     any;
      longint best_sum;
      longint a, b, c;
      any = 0;
      best_sum = 0;
      for (int t = 0; t < nt; t++) begin
        a = scores[(t * 8 + l0) * 32 + s0];
        b = scores[(t * 8 + l1) * 32 + s1];
        c = scores[(t * 8 + l2) * 32 + s2];
        if (a == ZERO_PROB || b == ZERO_PROB || c == ZERO_PROB) continue;
        if (!any || a + b + c < best_sum) begin
          best_sum = a + b + c;
          any = 1;
        end
      end
      if (!any) return longint'(alpha);
      return (longint'(scale) * best_sum) >> 16;
    endfunction

    function icm_result_t update_site(int s);
      int          ns, nl, nt;
      longint      total, best_total;
      int          best_lab;
      icm_result_t r;
      ns = n_sites > 32 ? 32 : n_sites;
      nl = n_labels == 0 ? 1 : (n_labels > 8 ? 8 : n_labels);
      nt = n_sets > 4 ? 4 : n_sets;
      best_total = 0;
      best_lab = 0;
      for (int f = 0; f < nl; f++) begin
        total = use_dc ? 6 * ns * longint'(dcost[f * 32 + s]) : 0;
        for (int j = 0; j < ns; j++) begin
          if (j == s) continue;
          for (int k = 0; k < ns; k++) begin
            if (k == s || k == j) continue;
            total += 3 * triplet(s, f, j, labels[j], k, labels[k], nt);
          end
        end
        if (f == 0 || total < best_total) begin
          best_total = total;
          best_lab = f;
        end
      end
      labels[s] = best_lab;
      r.kind = 0;
      r.st = s;
      r.lab = best_lab;
      r.energy = best_total[39:0];
      return r;
    endfunction

    function void note(logic [2:0] m, logic [1:0] si, logic [4:0] s, logic [2:0] l,
                       logic [15:0] v);
      icm_result_t r;
      case (m)
        MODE_LOAD_SCORE: scores[{si, l, s}] = v;
        MODE_LOAD_DATA:  dcost[{l, s}] = v;
        MODE_SET_LABEL:  labels[s] = l;
        MODE_UPDATE:     add_wanted(update_site(s));
        MODE_READ: begin
          r.kind = 1;
          r.st = s;
          r.lab = labels[s];
          r.energy = '0;
          add_wanted(r);
        end
        default: ;
      endcase
    endfunction

    function void check(icm_result_t got);
      icm_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result for site %0d", got.st);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind) begin
        $error("result_kind expected %0d actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.st !== want.st) begin
        $error("out_site expected %0d actual %0d", want.st, got.st);
        errors++;
      end
      if (got.lab !== want.lab) begin
        $error("out_label expected %0d actual %0d", want.lab, got.lab);
        errors++;
      end
      if (got.energy !== want.energy) begin
        $error("energy_times_six expected %0d actual %0d", want.energy, got.energy);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [2:0]  mode;
  logic [1:0]  set_index;
  logic [4:0]  site;
  logic [2:0]  label;
  logic [15:0] value;
  logic        done;
  logic        result_kind;
  logic [4:0]  out_site;
  logic [2:0]  out_label;
  logic [39:0] energy_times_six;

  label_sb sb;
  int      idle_pct;

  icm_triplet_label_update_top u_top (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  always @(posedge clk) begin
    icm_result_t got;
    if (!rst && done) begin
      got.kind = result_kind;
      got.st = out_site;
      got.lab = out_label;
      got.energy = energy_times_six;
      sb.check(got);
    end
  end

  task automatic send(logic [2:0] m, logic [1:0] si, logic [4:0] s, logic [2:0] l,
                      logic [15:0] v);
    start <= 1'b1;
    mode <= m;
    set_index <= si;
    site <= s;
    label <= l;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(m, si, s, l, v);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 5'(idx) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic configure(int ns, int nl, int nt, int a, int sc, int dc);
    drain();
    reg_write(REG_SITES, ns);
    reg_write(REG_LABELS, nl);
    reg_write(REG_SETS, nt);
    reg_write(REG_ALPHA, a);
    reg_write(REG_SCALE, sc);
    reg_write(REG_USE_DC, dc);
  endtask

  function automatic logic [15:0] rand_score();
    case ($urandom_range(7))
      0: return ZERO_PROB;
      1: return 16'h0000;
      2: return 16'($urandom);
      default: return 16'($urandom_range(16'h3FFF));
    endcase
  endfunction

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25)
      send(MODE_LOAD_SCORE, 2'($urandom), 5'($urandom_range(2)), 3'($urandom_range(3)),
           rand_score());
    else if (pick < 35)
      send(MODE_LOAD_DATA, 2'($urandom), 5'($urandom_range(2)), 3'($urandom_range(3)),
           16'($urandom));
    else if (pick < 50)
      send(MODE_SET_LABEL, 2'($urandom), 5'($urandom), 3'($urandom_range(3)),
           16'($urandom));
    else if (pick < 80)
      send(MODE_UPDATE, 2'($urandom), 5'($urandom_range(2)), 3'($urandom), 16'($urandom));
    else if (pick < 95)
      send(MODE_READ, 2'($urandom), 5'($urandom), 3'($urandom), 16'($urandom));
    else
      send(3'($urandom_range(5, 7)), 2'($urandom), 5'($urandom), 3'($urandom),
           16'($urandom));
  endtask

  initial begin
    int phase_idle[3];
    sb = new();
    sb.reset_state();
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; mode = '0; set_index = '0; site = '0; label = '0; value = '0;
    idle_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill sites 0 to 2, labels 0 to 3, all sets; updates stay inside this region
    for (int t = 0; t < 4; t++)
      for (int l = 0; l < 4; l++)
        for (int s = 0; s < 3; s++)
          send(MODE_LOAD_SCORE, 2'(t), 5'(s), 3'(l), rand_score());
    for (int l = 0; l < 4; l++)
      for (int s = 0; s < 3; s++)
        send(MODE_LOAD_DATA, 2'd0, 5'(s), 3'(l), 16'($urandom));

    send(MODE_READ, 2'd0, 5'd31, 3'd0, 16'd0);
    send(3'd7, 2'd3, 5'd31, 3'd7, 16'hFFFF);
    send(3'd5, 2'd0, 5'd0, 3'd0, 16'h0000);
    send(3'd6, 2'd1, 5'd10, 3'd2, 16'h5555);
    send(MODE_SET_LABEL, 2'd3, 5'd31, 3'd3, 16'hFFFF);
    send(MODE_READ, 2'd3, 5'd31, 3'd7, 16'hFFFF);
    configure(3, 4, 7, 16'hFFFF, 16'hFFFF, 1);
    send(MODE_UPDATE, 2'd0, 5'd0, 3'd0, 16'd0);
    send(MODE_UPDATE, 2'd0, 5'd2, 3'd0, 16'd0);
    configure(2, 0, 0, 7, 9, 1);
    send(MODE_UPDATE, 2'd0, 5'd2, 3'd0, 16'd0);
    configure(0, 3, 2, 100, 300, 0);
    send(MODE_UPDATE, 2'd0, 5'd1, 3'd0, 16'd0);

    phase_idle = '{0, 65, 34};
    for (int ph = 0; ph < 3; ph++) begin
      configure(3, $urandom_range(0, 4), $urandom_range(0, 7),
                $urandom_range(3) == 0 ? 16'hFFFF : $urandom_range(16'hFFFF),
                $urandom_range(3) == 0 ? 16'hFFFF : $urandom_range(16'hFFFF),
                $urandom_range(1));
      idle_pct = phase_idle[ph];
      for (int n = 0; n < 22; n++) begin
        if (ph == 1 && n == 11) begin
          start <= 1'b0;
          while (sb.pending.size() != 0) @(posedge clk);
        end
        random_item();
      end
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule

// ===== icm_triplet_label_update_top.f =====
design/icm_pkg.sv
design/icm_ram.sv
design/icm_triplet_label_update_top.sv
design/icm_checker.sv
verif/tb.sv
